// ===== sv/hdtx_pkg.sv =====
package hdtx_pkg;

  // Phase codes as they appear on tx_phase
  localparam logic [1:0] TX_PHASE_IDLE = 2'd0;
  localparam logic [1:0] TX_PHASE_WAIT = 2'd1;
  localparam logic [1:0] TX_PHASE_SEND = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_OWN_ADDRESS       = 2'd0;
  localparam logic [1:0] CFG_MAX_RETRIES       = 2'd1;
  localparam logic [1:0] CFG_IGNORE_LINE_CHECK = 2'd2;

  // Input operations
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_ENQUEUE = 1'b1;

  // Transmitter status
  localparam logic signed [1:0] ST_DONE = 2'sd1;

  localparam int TIME_W    = 32;
  localparam int ATTEMPT_W = 5;
  localparam int ADDR_W    = 8;
  localparam int RETRY_W   = 4;
  localparam int PROD_W    = ADDR_W + ATTEMPT_W;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_WAIT = 3'b010,
    PH_SEND = 3'b100
  } phase_t;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    unique case (ph)
      PH_IDLE: code = TX_PHASE_IDLE;
      PH_WAIT: code = TX_PHASE_WAIT;
      PH_SEND: code = TX_PHASE_SEND;
      default: code = TX_PHASE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ===== sv/half_duplex_tx_retry_backoff.sv =====
// Transmit scheduler for a half-duplex shared line with binary exponential
// backoff.
// Input channel (in_valid/in_ready): one beat is either a millisecond tick
// (op = 0, with now_ms, rx_seen, line_busy, send_status) or an enqueue
// request (op = 1, other fields ignored).
// Output channel (out_valid/out_ready): exactly one result beat per input
// beat, in order: event flags, phase and attempt count after the step, and
// the sent-frame and collision counters.
// The state update and the result are computed in the cycle of acceptance and
// the result is registered. Throughput is one beat per cycle while the
// receiver does not stall; the single output register frees up in the cycle
// it is taken, so in_ready follows out_ready whenever a result is held.
// A receiver stall holds the result and holds off new input beats.
// Reset (rst, synchronous) returns to idle with zero attempts, clears all
// timestamps and counters, and loads own_address 0, max_retries 3 and
// ignore_line_check 0. Configuration writes (cfg_we, cfg_index, cfg_data)
// take effect at the next clock edge; unknown indexes are ignored.
module half_duplex_tx_retry_backoff (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [31:0] now_ms,
  input  logic        rx_seen,
  input  logic        line_busy,
  input  logic signed [1:0] send_status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic        start_send,
  output logic        send_done,
  output logic        collided,
  output logic        gave_up,
  output logic [1:0]  tx_phase,
  output logic [4:0]  attempts,
  output logic [31:0] frames_sent,
  output logic [31:0] collisions_total
);
  import hdtx_pkg::*;

  logic [ADDR_W-1:0]    own_address;
  logic [RETRY_W-1:0]   max_retries;
  logic                 ignore_line_check;

  phase_t               phase, phase_next;
  logic [ATTEMPT_W-1:0] attempt_count, attempt_count_next;
  logic [TIME_W-1:0]    retry_time, retry_time_next;
  logic [TIME_W-1:0]    last_activity, last_activity_next;
  logic [TIME_W-1:0]    sent_total, sent_total_next;
  logic [TIME_W-1:0]    collision_total, collision_total_next;

  logic take;
  logic acc_r, start_r, done_r, coll_r, gave_r;

  logic [TIME_W-1:0]    quiet_gap, retry_gap, backoff_mask;
  logic [ATTEMPT_W-1:0] attempt_inc;
  logic [PROD_W-1:0]    spread;
  logic                 line_idle;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // Activity seen on this tick counts as the latest activity
  assign quiet_gap    = now_ms - (rx_seen ? now_ms : last_activity);
  assign retry_gap    = now_ms - retry_time;
  assign attempt_inc  = attempt_count + ATTEMPT_W'(1);
  assign spread       = PROD_W'(own_address) * PROD_W'(attempt_inc);
  assign backoff_mask = (TIME_W'(8) << attempt_inc) - TIME_W'(1);

  // Backoff is waited out even when the line checks are skipped
  assign line_idle = (ignore_line_check || (quiet_gap > TIME_W'(1) && !line_busy))
                     && !(attempt_count != '0 && retry_gap[TIME_W-1]);

  always_comb begin
    phase_next           = phase;
    attempt_count_next   = attempt_count;
    retry_time_next      = retry_time;
    last_activity_next   = last_activity;
    sent_total_next      = sent_total;
    collision_total_next = collision_total;
    acc_r   = 1'b0;
    start_r = 1'b0;
    done_r  = 1'b0;
    coll_r  = 1'b0;
    gave_r  = 1'b0;
    if (op == OP_ENQUEUE) begin
      if (phase == PH_IDLE) begin
        phase_next         = PH_WAIT;
        attempt_count_next = '0;
        acc_r              = 1'b1;
      end
    end else begin
      if (rx_seen) begin
        last_activity_next = now_ms;
      end
      unique case (phase)
        PH_IDLE: ;
        PH_WAIT: begin
          if (attempt_count > ATTEMPT_W'(max_retries)) begin
            phase_next = PH_IDLE;
            gave_r     = 1'b1;
          end else if (line_idle) begin
            phase_next = PH_SEND;
            start_r    = 1'b1;
          end
        end
        PH_SEND: begin
          if (send_status == ST_DONE) begin
            phase_next      = PH_IDLE;
            done_r          = 1'b1;
            sent_total_next = sent_total + TIME_W'(1);
          end else if (send_status[1]) begin
            phase_next           = PH_WAIT;
            attempt_count_next   = attempt_inc;
            retry_time_next      = now_ms + TIME_W'(spread[PROD_W-1:1])
                                   + (now_ms & backoff_mask);
            collision_total_next = collision_total + TIME_W'(1);
            coll_r               = 1'b1;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address       <= '0;
      max_retries       <= RETRY_W'(3);
      ignore_line_check <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_ADDRESS:       own_address       <= cfg_data;
        CFG_MAX_RETRIES:       max_retries       <= cfg_data[RETRY_W-1:0];
        CFG_IGNORE_LINE_CHECK: ignore_line_check <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      attempt_count   <= '0;
      retry_time      <= '0;
      last_activity   <= '0;
      sent_total      <= '0;
      collision_total <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (take) begin
        phase           <= phase_next;
        attempt_count   <= attempt_count_next;
        retry_time      <= retry_time_next;
        last_activity   <= last_activity_next;
        sent_total      <= sent_total_next;
        collision_total <= collision_total_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; hold while stalled
  always_ff @(posedge clk) begin
    if (take) begin
      accepted         <= acc_r;
      start_send       <= start_r;
      send_done        <= done_r;
      collided         <= coll_r;
      gave_up          <= gave_r;
      tx_phase         <= phase_code(phase_next);
      attempts         <= attempt_count_next;
      frames_sent      <= sent_total_next;
      collisions_total <= collision_total_next;
    end
  end

  a_one_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({accepted, start_send, send_done, collided, gave_up}) <= 1)
    else $error("more than one event flag in one result");

  a_enqueue_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> tx_phase == TX_PHASE_WAIT && attempts == '0)
    else $error("accepted frame not waiting with zero attempts");

  a_collide_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid && collided |-> tx_phase == TX_PHASE_WAIT && attempts != '0)
    else $error("collision did not schedule a retry");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && (send_done || gave_up) |-> tx_phase == TX_PHASE_IDLE)
    else $error("finished frame left phase busy");

  a_attempt_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> attempts <= ATTEMPT_W'(16))
    else $error("attempt count out of range");

endmodule

// ===== dv/tb.sv =====
module tb;
  import hdtx_pkg::*;

  // Transmitter status codes not named in the package
  localparam logic [1:0] ST_IN_PROGRESS   = 2'b00;
  localparam logic [1:0] ST_COLLISION     = 2'b11;
  localparam logic [1:0] ST_COLLISION_ALT = 2'b10;

  localparam int BEATS_PER_PHASE = 275;
  localparam int NUM_PHASES      = 6;
  localparam int MAX_TICKS_PER_FRAME = 150;

  typedef struct packed {
    logic        op;
    logic [31:0] now_ms;
    logic        rx_seen;
    logic        line_busy;
    logic [1:0]  send_status;
  } tx_event_t;

  typedef struct packed {
    logic        accepted;
    logic        start_send;
    logic        send_done;
    logic        collided;
    logic        gave_up;
    logic [1:0]  tx_phase;
    logic [4:0]  attempts;
    logic [31:0] frames_sent;
    logic [31:0] collisions_total;
  } tx_result_t;

  class tx_scoreboard;
    logic [7:0]  own_addr;
    logic [3:0]  retry_limit;
    logic        skip_line_check;
    logic [1:0]  phase;
    logic [4:0]  tries;
    logic [31:0] retry_at;
    logic [31:0] last_rx;
    logic [31:0] sent_cnt;
    logic [31:0] coll_cnt;
    tx_result_t  expected_q[$];
    int errors, beats, checked, n_start, n_done, n_coll, n_drop, n_refused;

    function new();
      own_addr = 8'd0;
      retry_limit = 4'd3;
      skip_line_check = 1'b0;
      phase = TX_PHASE_IDLE;
      tries = '0;
      retry_at = '0;
      last_rx = '0;
      sent_cnt = '0;
      coll_cnt = '0;
      errors = 0;
      beats = 0;
      checked = 0;
      n_start = 0;
      n_done = 0;
      n_coll = 0;
      n_drop = 0;
      n_refused = 0;
    endfunction

    function void configure(logic [7:0] addr, logic [3:0] limit, logic skip);
      own_addr = addr;
      retry_limit = limit;
      skip_line_check = skip;
    endfunction

    // Advance the transmit state by one accepted beat and queue its result
    function void note(tx_event_t ev);
      tx_result_t  r;
      logic [31:0] quiet;
      logic [31:0] lag;
      logic [31:0] window;
      logic        free;
      r = '0;
      if (ev.op == OP_ENQUEUE) begin
        if (phase == TX_PHASE_IDLE) begin
          phase = TX_PHASE_WAIT;
          tries = '0;
          r.accepted = 1'b1;
        end else begin
          n_refused++;
        end
      end else begin
        if (ev.rx_seen) last_rx = ev.now_ms;
        case (phase)
          TX_PHASE_IDLE: ;
          TX_PHASE_WAIT: begin
            if (tries > {1'b0, retry_limit}) begin
              phase = TX_PHASE_IDLE;
              r.gave_up = 1'b1;
            end else begin
              quiet = ev.now_ms - last_rx;
              free = (quiet > 32'd1) && !ev.line_busy;
              if (skip_line_check) free = 1'b1;
              // backoff still applies with the line check skipped
              lag = ev.now_ms - retry_at;
              if (free && tries != '0 && lag[31]) free = 1'b0;
              if (free) begin
                phase = TX_PHASE_SEND;
                r.start_send = 1'b1;
              end
            end
          end
          TX_PHASE_SEND: begin
            if (ev.send_status == ST_DONE) begin
              phase = TX_PHASE_IDLE;
              sent_cnt = sent_cnt + 32'd1;
              r.send_done = 1'b1;
            end else if (ev.send_status[1]) begin
              phase = TX_PHASE_WAIT;
              tries = tries + 5'd1;
              window = (32'd8 << tries) - 32'd1;
              retry_at = ev.now_ms + ((32'(own_addr) * 32'(tries)) >> 1)
                         + (ev.now_ms & window);
              coll_cnt = coll_cnt + 32'd1;
              r.collided = 1'b1;
            end
          end
          default: phase = TX_PHASE_IDLE;
        endcase
      end
      r.tx_phase = phase;
      r.attempts = tries;
      r.frames_sent = sent_cnt;
      r.collisions_total = coll_cnt;
      n_start += r.start_send;
      n_done += r.send_done;
      n_coll += r.collided;
      n_drop += r.gave_up;
      beats++;
      expected_q.push_back(r);
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 60)
          $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check(tx_result_t got);
      tx_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 60)
          $display("%0t: result beat with nothing outstanding: expected none, got %h",
                   $time, got);
        return;
      end
      want = expected_q.pop_front();
      match_field("accepted", want.accepted, got.accepted);
      match_field("start_send", want.start_send, got.start_send);
      match_field("send_done", want.send_done, got.send_done);
      match_field("collided", want.collided, got.collided);
      match_field("gave_up", want.gave_up, got.gave_up);
      match_field("tx_phase", want.tx_phase, got.tx_phase);
      match_field("attempts", want.attempts, got.attempts);
      match_field("frames_sent", want.frames_sent, got.frames_sent);
      match_field("collisions_total", want.collisions_total, got.collisions_total);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_OWN_ADDRESS;
  logic [7:0]         cfg_data = 8'd0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               op = OP_TICK;
  logic [31:0]        now_ms = 32'd0;
  logic               rx_seen = 1'b0;
  logic               line_busy = 1'b0;
  logic signed [1:0]  send_status = 2'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               accepted;
  logic               start_send;
  logic               send_done;
  logic               collided;
  logic               gave_up;
  logic [1:0]         tx_phase;
  logic [4:0]         attempts;
  logic [31:0]        frames_sent;
  logic [31:0]        collisions_total;

  tx_scoreboard book;
  int unsigned  send_idle_pct = 0;
  int unsigned  ready_stall_pct = 0;
  logic [31:0]  clock_ms = 32'd0;

  half_duplex_tx_retry_backoff DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Receive side: check each result beat, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      book.check({accepted, start_send, send_done, collided, gave_up, tx_phase,
                  attempts, frames_sent, collisions_total});
    out_ready <= ($urandom_range(99) >= ready_stall_pct);
  end

  // Hold the beat until accepted; the caller drives the next one in the same step
  task automatic push(input tx_event_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= ev.op;
    now_ms      <= ev.now_ms;
    rx_seen     <= ev.rx_seen;
    line_busy   <= ev.line_busy;
    send_status <= ev.send_status;
    do @(posedge clk); while (!in_ready);
    book.note(ev);
  endtask

  task automatic enqueue();
    tx_event_t ev;
    ev = tx_event_t'({$urandom, $urandom});
    ev.op = OP_ENQUEUE;
    push(ev);
  endtask

  task automatic tick(input logic [31:0] t, input logic rx, input logic busy,
                      input logic [1:0] st);
    tx_event_t ev;
    ev.op = OP_TICK;
    ev.now_ms = t;
    ev.rx_seen = rx;
    ev.line_busy = busy;
    ev.send_status = st;
    push(ev);
  endtask

  // Status is shaped by the predicted phase so that collisions land while sending
  function automatic logic [1:0] pick_status(bit storm);
    int unsigned roll;
    roll = $urandom_range(99);
    if (book.phase != TX_PHASE_SEND) return 2'($urandom);
    if (roll < (storm ? 90 : 30))
      return $urandom_range(1) ? ST_COLLISION : ST_COLLISION_ALT;
    if (roll < (storm ? 93 : 60)) return ST_DONE;
    return ST_IN_PROGRESS;
  endfunction

  function automatic tx_event_t tick_event(bit storm);
    tx_event_t   ev;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) clock_ms += $urandom_range(3);
    else if (roll < 75) clock_ms += $urandom_range(4096);
    else if (roll < 95) clock_ms += $urandom_range(1 << 20);
    else clock_ms = $urandom;
    ev.op = OP_TICK;
    ev.now_ms = clock_ms;
    ev.rx_seen = ($urandom_range(99) < 10);
    ev.line_busy = ($urandom_range(99) < 20);
    ev.send_status = pick_status(storm);
    return ev;
  endfunction

  task automatic set_config(input logic [7:0] addr, input logic [3:0] limit,
                            input logic skip);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OWN_ADDRESS;
    cfg_data  <= addr;
    @(posedge clk);
    cfg_index <= CFG_MAX_RETRIES;
    cfg_data  <= {4'd0, limit};
    @(posedge clk);
    cfg_index <= CFG_IGNORE_LINE_CHECK;
    cfg_data  <= {7'd0, skip};
    @(posedge clk);
    cfg_we <= 1'b0;
    book.configure(addr, limit, skip);
  endtask

  // Drop valid, drain all outstanding results, then let the pipe go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int  sent;
    int  ticks;
    bit  storm;
    book = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset configuration, no idling
    tick(32'd0, 1'b0, 1'b0, ST_IN_PROGRESS);
    enqueue();
    enqueue();                                  // refused while pending
    tick(32'd1, 1'b0, 1'b0, ST_DONE);           // quiet for only 1 ms
    tick(32'd2, 1'b0, 1'b1, ST_IN_PROGRESS);    // line busy
    tick(32'd2, 1'b0, 1'b0, ST_IN_PROGRESS);    // start
    tick(32'd3, 1'b0, 1'b0, ST_IN_PROGRESS);
    tick(32'd4, 1'b0, 1'b0, ST_COLLISION);
    tick(32'd5, 1'b0, 1'b0, ST_IN_PROGRESS);    // inside backoff
    tick(32'd8, 1'b0, 1'b0, ST_IN_PROGRESS);    // backoff just over
    tick(32'd9, 1'b1, 1'b0, ST_COLLISION_ALT);
    tick(32'd18, 1'b1, 1'b1, ST_IN_PROGRESS);   // activity this tick
    tick(32'd20, 1'b0, 1'b0, ST_IN_PROGRESS);
    tick(32'd21, 1'b0, 1'b0, ST_DONE);
    enqueue();
    tick(32'hFFFF_FFFF, 1'b1, 1'b1, ST_COLLISION);
    tick(32'd1, 1'b0, 1'b0, ST_IN_PROGRESS);    // quiet across the wrap
    tick(32'd2, 1'b0, 1'b0, ST_COLLISION);
    tick(32'h0000_0100, 1'b0, 1'b0, ST_IN_PROGRESS);
    tick(32'h0000_0101, 1'b0, 1'b0, ST_COLLISION);
    tick(32'h0001_0000, 1'b0, 1'b0, ST_IN_PROGRESS);
    tick(32'h0001_0001, 1'b0, 1'b0, ST_COLLISION);
    tick(32'h0002_0000, 1'b0, 1'b0, ST_IN_PROGRESS);
    tick(32'h0002_0001, 1'b0, 1'b0, ST_COLLISION);
    tick(32'h0003_0000, 1'b0, 1'b0, ST_IN_PROGRESS); // over the retry limit: drop
    tick(32'h0003_0001, 1'b0, 1'b0, ST_DONE);        // idle, status ignored
    clock_ms = 32'h0003_0001;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1: set_config(8'hFF, 4'd15, 1'b0);
          2: set_config(8'h00, 4'd0, 1'b1);
          3: set_config(8'($urandom), 4'($urandom), 1'($urandom));
          4: set_config(8'hFF, 4'd15, 1'b1);
          default: set_config(8'($urandom), 4'd1, 1'b0);
        endcase
        if (p >= 3) clock_ms = $urandom;
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
        1: begin send_idle_pct = 84; ready_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  ready_stall_pct = 84; end
        default: begin send_idle_pct = 28; ready_stall_pct = 28; end
      endcase
      sent = 0;
      while (sent < BEATS_PER_PHASE) begin
        if ($urandom_range(99) < 15) begin
          // noise: any field combination
          push(tx_event_t'({$urandom, $urandom}));
          sent++;
        end else begin
          storm = ($urandom_range(99) < 30);
          enqueue();
          sent++;
          if ($urandom_range(99) < 15) begin
            enqueue();
            sent++;
          end
          ticks = 0;
          do begin
            push(tick_event(storm));
            sent++;
            ticks++;
          end while (book.phase != TX_PHASE_IDLE && ticks < MAX_TICKS_PER_FRAME);
        end
      end
    end
    settle();

    $display("Covered %0d beats over %0d register settings, %0d results checked.",
             book.beats, NUM_PHASES, book.checked);
    $display("Sends started %0d, completed %0d, collisions %0d, dropped %0d, refused %0d.",
             book.n_start, book.n_done, book.n_coll, book.n_drop, book.n_refused);
    if (book.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
